// ===== design/fcbp_pkg.sv =====
// fcbp_pkg: types, character constants and helper functions for the
// 8.3 file control block parser. No dependencies.
package fcbp_pkg;

  localparam int CONSUMED_MAX = 255;
  localparam int COUNT_LIMIT  = (CONSUMED_MAX < 255) ? CONSUMED_MAX : 255;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_LOA   = 8'h61;
  localparam logic [7:0] CH_LOZ   = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'd32;
  localparam logic [7:0] BAD_DRIVE = 8'hFF;

  localparam int OPT_SKIP_SEP   = 0;
  localparam int OPT_KEEP_DRIVE = 1;
  localparam int OPT_KEEP_NAME  = 2;
  localparam int OPT_KEEP_EXT   = 3;

  localparam int NAME_LEN = 8;
  localparam int EXT_LEN  = 3;

  localparam logic [3:0] LAST_OFFSET = 4'd15;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SKIPSEP = 3'd1,
    PH_SKIPWS  = 3'd2,
    PH_DRVWAIT = 3'd3,
    PH_NAME    = 3'd4,
    PH_DOTCHK  = 3'd5,
    PH_EXT     = 3'd6
  } phase_e;

  typedef struct packed {
    logic [NAME_LEN-1:0][7:0] name;
    logic [3:0]               idx;
    logic                     wild;
    logic [7:0]               cnt;
  } name_st_t;

  function automatic logic is_delim(logic [7:0] c);
    return (c inside {8'h2E, 8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3A, 8'h2B, 8'h3D,
                      8'h3B, 8'h2C, CH_TAB, CH_SPACE}) ||
           (c < 8'd32) || (c >= 8'd128);
  endfunction

  // upper-cased character, zero for terminator or delimiter
  function automatic logic [7:0] letter_of(logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= CH_LOA && c <= CH_LOZ) begin
      u = c - CASE_GAP;
    end
    if (c == CH_NUL || is_delim(u)) begin
      u = CH_NUL;
    end
    return u;
  endfunction

  function automatic logic [7:0] count_up(logic [7:0] cnt);
    return (cnt < 8'(COUNT_LIMIT)) ? cnt + 8'd1 : cnt;
  endfunction

  function automatic name_st_t name_take(name_st_t s, logic [7:0] g);
    name_st_t r;
    r = s;
    if (g == CH_STAR) begin
      for (int i = 0; i < NAME_LEN; i++) begin
        if (4'(i) >= r.idx) begin
          r.name[i] = CH_QMARK;
        end
      end
      r.idx  = 4'(NAME_LEN);
      r.wild = 1'b1;
    end else begin
      r.name[r.idx[2:0]] = g;
      r.idx = r.idx + 4'd1;
      if (g == CH_QMARK) begin
        r.wild = 1'b1;
      end
    end
    r.cnt = count_up(r.cnt);
    return r;
  endfunction

endpackage

// ===== design/filename_to_fcb_parser.sv =====
// filename_to_fcb_parser: streams text characters into an 8.3 file control
// block image and drains the 16 image bytes when a parse ends.
// Depends on fcbp_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per character:
//   ch_i and start_req_i. start_req_i = 1 opens a new parse on that character.
//   Output channel (out_valid_o / out_stall_i) carries one image byte per
//   word: fcb_offset_o, fcb_byte_o, last_o, wildcard_res_o, consumed_o.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes parse_options
//   (4 bits); it is always ready and takes effect on the next character.
// Throughput: one character per cycle while in_stall_o is low. Each
//   character is decided in the cycle it is accepted, in one pass of logic
//   between the state registers.
// Output: the first byte of a finished parse shows on the output in the
//   cycle after the ending character; the 16 bytes then leave at one per
//   cycle that out_stall_i is low. The finished image is copied to an output
//   frame, so characters keep flowing while it drains; in_stall_o rises only
//   for a character that would end a parse before the previous frame has left.
// Reset: returns to idle, options zero; characters are ignored until a
//   start_req_i. A stall on the output holds the current byte in place.
module filename_to_fcb_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       start_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] fcb_offset_o,
  output logic [7:0] fcb_byte_o,
  output logic       last_o,
  output logic       wildcard_res_o,
  output logic [7:0] consumed_o
);

  fcbp_pkg::phase_e                           phase_q, phase_d;
  logic [3:0]                                 opts_q;
  logic [7:0]                                 held_q, held_d;
  logic [3:0]                                 name_idx_q, name_idx_d;
  logic [1:0]                                 ext_idx_q, ext_idx_d;
  logic                                       wild_q, wild_d;
  logic [7:0]                                 cnt_q, cnt_d;
  logic [7:0]                                 drive_q, drive_d;
  logic [fcbp_pkg::NAME_LEN-1:0][7:0]         name_q, name_d;
  logic [fcbp_pkg::EXT_LEN-1:0][7:0]          ext_q, ext_d;
  logic [7:0]                                 frm_drive_q;
  logic [fcbp_pkg::NAME_LEN-1:0][7:0]         frm_name_q;
  logic [fcbp_pkg::EXT_LEN-1:0][7:0]          frm_ext_q;
  logic                                       frm_wild_q;
  logic [7:0]                                 frm_cnt_q;
  logic                                       out_valid_q, out_valid_d;
  logic [3:0]                                 out_idx_q, out_idx_d;
  logic                                       in_fin;
  logic                                       in_acc;
  logic                                       fin_acc;
  logic                                       out_acc;
  logic                                       out_free;

  assign cfg_ready_o = 1'b1;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || (out_acc && out_idx_q == fcbp_pkg::LAST_OFFSET);
  assign in_stall_o  = in_fin && !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign fin_acc     = in_acc && in_fin;

  always_comb begin
    fcbp_pkg::phase_e   ph;
    fcbp_pkg::name_st_t ns;
    logic [7:0]         g;
    logic               done;
    logic               fin;

    ph          = phase_q;
    held_d      = held_q;
    ext_idx_d   = ext_idx_q;
    drive_d     = drive_q;
    ext_d       = ext_q;
    ns.name     = name_q;
    ns.idx      = name_idx_q;
    ns.wild     = wild_q;
    ns.cnt      = cnt_q;
    done        = 1'b0;
    fin         = 1'b0;
    g           = fcbp_pkg::CH_NUL;

    if (in_valid_i) begin
      if (start_req_i) begin
        ns.idx    = 4'd0;
        ext_idx_d = 2'd0;
        ns.wild   = 1'b0;
        ns.cnt    = 8'd0;
        held_d    = fcbp_pkg::CH_NUL;
        if (!opts_q[fcbp_pkg::OPT_KEEP_DRIVE]) begin
          drive_d = fcbp_pkg::CH_NUL;
        end
        if (!opts_q[fcbp_pkg::OPT_KEEP_NAME]) begin
          for (int i = 0; i < fcbp_pkg::NAME_LEN; i++) begin
            ns.name[i] = fcbp_pkg::CH_SPACE;
          end
        end
        if (!opts_q[fcbp_pkg::OPT_KEEP_EXT]) begin
          for (int i = 0; i < fcbp_pkg::EXT_LEN; i++) begin
            ext_d[i] = fcbp_pkg::CH_SPACE;
          end
        end
        ph = opts_q[fcbp_pkg::OPT_SKIP_SEP] ? fcbp_pkg::PH_SKIPSEP : fcbp_pkg::PH_SKIPWS;
      end

      if (ph == fcbp_pkg::PH_SKIPSEP) begin
        if (ch_i != fcbp_pkg::CH_NUL && fcbp_pkg::is_delim(ch_i) &&
            ch_i != fcbp_pkg::CH_COLON) begin
          ns.cnt = fcbp_pkg::count_up(ns.cnt);
          done   = 1'b1;
        end else begin
          ph = fcbp_pkg::PH_SKIPWS;
          if (ch_i == fcbp_pkg::CH_COLON) begin
            ns.cnt = fcbp_pkg::count_up(ns.cnt);
            done   = 1'b1;
          end
        end
      end

      if (!done && ph == fcbp_pkg::PH_SKIPWS) begin
        if (ch_i == fcbp_pkg::CH_SPACE || ch_i == fcbp_pkg::CH_TAB) begin
          ns.cnt = fcbp_pkg::count_up(ns.cnt);
          done   = 1'b1;
        end else if (fcbp_pkg::letter_of(ch_i) != fcbp_pkg::CH_NUL) begin
          held_d = ch_i;
          ph     = fcbp_pkg::PH_DRVWAIT;
          done   = 1'b1;
        end else begin
          ph = fcbp_pkg::PH_NAME;
        end
      end

      if (!done && ph == fcbp_pkg::PH_DRVWAIT) begin
        g = fcbp_pkg::letter_of(held_q);
        if (ch_i == fcbp_pkg::CH_COLON) begin
          drive_d = (g >= fcbp_pkg::CH_UPA && g <= fcbp_pkg::CH_UPZ) ?
                    g - fcbp_pkg::CH_AT : fcbp_pkg::BAD_DRIVE;
          ns.cnt  = fcbp_pkg::count_up(fcbp_pkg::count_up(ns.cnt));
          ph      = fcbp_pkg::PH_NAME;
          done    = 1'b1;
        end else begin
          ph = fcbp_pkg::PH_NAME;
          if (g != fcbp_pkg::CH_NUL) begin
            ns = fcbp_pkg::name_take(ns, g);
            if (ns.idx >= 4'(fcbp_pkg::NAME_LEN)) begin
              ph = fcbp_pkg::PH_DOTCHK;
            end
          end
        end
      end

      if (!done && ph == fcbp_pkg::PH_NAME) begin
        g = fcbp_pkg::letter_of(ch_i);
        if (g == fcbp_pkg::CH_NUL) begin
          ph = fcbp_pkg::PH_DOTCHK;
        end else begin
          ns = fcbp_pkg::name_take(ns, g);
          if (ns.idx >= 4'(fcbp_pkg::NAME_LEN)) begin
            ph = fcbp_pkg::PH_DOTCHK;
          end
          done = 1'b1;
        end
      end

      if (!done && ph == fcbp_pkg::PH_DOTCHK) begin
        if (ch_i == fcbp_pkg::CH_DOT) begin
          ns.cnt    = fcbp_pkg::count_up(ns.cnt);
          ext_idx_d = 2'd0;
          ph        = fcbp_pkg::PH_EXT;
        end else begin
          fin = 1'b1;
        end
        done = 1'b1;
      end

      if (!done && ph == fcbp_pkg::PH_EXT) begin
        g = fcbp_pkg::letter_of(ch_i);
        if (g == fcbp_pkg::CH_NUL) begin
          fin = 1'b1;
        end else begin
          ns.cnt = fcbp_pkg::count_up(ns.cnt);
          if (g == fcbp_pkg::CH_STAR) begin
            for (int i = 0; i < fcbp_pkg::EXT_LEN; i++) begin
              if (2'(i) >= ext_idx_d) begin
                ext_d[i] = fcbp_pkg::CH_QMARK;
              end
            end
            ext_idx_d = 2'(fcbp_pkg::EXT_LEN);
            ns.wild   = 1'b1;
            fin       = 1'b1;
          end else begin
            ext_d[ext_idx_d] = g;
            ext_idx_d        = ext_idx_d + 2'd1;
            if (g == fcbp_pkg::CH_QMARK) begin
              ns.wild = 1'b1;
            end
            if (ext_idx_d >= 2'(fcbp_pkg::EXT_LEN)) begin
              fin = 1'b1;
            end
          end
        end
      end

      if (fin) begin
        ph = fcbp_pkg::PH_IDLE;
      end
    end

    in_fin     = fin;
    phase_d    = ph;
    name_d     = ns.name;
    name_idx_d = ns.idx;
    wild_d     = ns.wild;
    cnt_d      = ns.cnt;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    if (fin_acc) begin
      out_valid_d = 1'b1;
      out_idx_d   = 4'd0;
    end else if (out_acc) begin
      if (out_idx_q == fcbp_pkg::LAST_OFFSET) begin
        out_valid_d = 1'b0;
      end else begin
        out_idx_d = out_idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fcbp_pkg::PH_IDLE;
      opts_q      <= 4'd0;
      held_q      <= 8'd0;
      name_idx_q  <= 4'd0;
      ext_idx_q   <= 2'd0;
      wild_q      <= 1'b0;
      cnt_q       <= 8'd0;
      frm_wild_q  <= 1'b0;
      frm_cnt_q   <= 8'd0;
      out_valid_q <= 1'b0;
      out_idx_q   <= 4'd0;
    end else begin
      if (in_acc) begin
        phase_q    <= phase_d;
        held_q     <= held_d;
        name_idx_q <= name_idx_d;
        ext_idx_q  <= ext_idx_d;
        wild_q     <= wild_d;
        cnt_q      <= cnt_d;
      end
      if (fin_acc) begin
        frm_wild_q <= wild_d;
        frm_cnt_q  <= cnt_d;
      end
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        opts_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      drive_q <= drive_d;
      name_q  <= name_d;
      ext_q   <= ext_d;
    end
    if (fin_acc) begin
      frm_drive_q <= drive_d;
      frm_name_q  <= name_d;
      frm_ext_q   <= ext_d;
    end
  end

  always_comb begin
    case (out_idx_q) inside
      4'd0:          fcb_byte_o = frm_drive_q;
      [4'd1:4'd8]:   fcb_byte_o = frm_name_q[3'(out_idx_q - 4'd1)];
      [4'd9:4'd11]:  fcb_byte_o = frm_ext_q[2'(out_idx_q - 4'd9)];
      default:       fcb_byte_o = fcbp_pkg::CH_NUL;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign fcb_offset_o   = out_idx_q;
  assign last_o         = (out_idx_q == fcbp_pkg::LAST_OFFSET);
  assign wildcard_res_o = frm_wild_q;
  assign consumed_o     = frm_cnt_q;

endmodule

// ===== design/fcbp_checker.sv =====
// fcbp_checker: port-level checks on the drain sequence of the parser,
// bound to filename_to_fcb_parser. Depends on fcbp_pkg.
module fcbp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] fcb_offset_o,
  input logic       last_o
);

  a_stall_while_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |-> out_valid_o)
    else $error("input held while no image drains");

  a_drain_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (fcb_offset_o == 4'd0))
    else $error("drain does not start at offset zero");

  a_offset_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=>
      (out_valid_o && fcb_offset_o == $past(fcb_offset_o) + 4'd1))
    else $error("drain offset skipped or stopped");

  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (fcb_offset_o == fcbp_pkg::LAST_OFFSET)))
    else $error("last flag on wrong offset");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> (!out_valid_o || fcb_offset_o == 4'd0))
    else $error("word shown after final byte");

endmodule

bind filename_to_fcb_parser fcbp_checker u_fcbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .fcb_offset_o (fcb_offset_o),
  .last_o       (last_o)
);

// ===== tb/filename_to_fcb_parser_tb.sv =====
`timescale 1ns / 1ps
// filename_to_fcb_parser_tb: drives directed and random file name text into the
// 8.3 control block parser and checks every drained image word against a predictor.
// Depends on fcbp_pkg and filename_to_fcb_parser.
module filename_to_fcb_parser_tb;

  localparam int WATCHDOG_LIMIT = 2500;
  localparam int PHASE_CHARS    = 4;
  localparam int RANDOM_PHASES  = 3;
  localparam int SAT_RUN        = 250;

  typedef struct packed {
    logic [3:0] offset;
    logic [7:0] value;
    logic       last;
    logic       wild;
    logic [7:0] count;
  } fcb_word_t;

  class fcb_image_tracker;
    logic [3:0]       opts;
    fcbp_pkg::phase_e ph;
    logic [7:0]       held;
    logic [7:0]       count;
    int               name_pos;
    int               ext_pos;
    logic             wild;
    logic [7:0]       image [16];
    fcb_word_t        image_bytes_due [$];
    int               errors;
    int               bytes_checked;
    int               parses_closed;
    int               option_writes;

    function new();
      opts = '0;
      ph = fcbp_pkg::PH_IDLE;
      held = '0;
      count = '0;
      name_pos = 0;
      ext_pos = 0;
      wild = 1'b0;
      foreach (image[i]) image[i] = '0;
      errors = 0;
      bytes_checked = 0;
      parses_closed = 0;
      option_writes = 0;
    endfunction

    function void set_options(logic [3:0] v);
      opts = v;
      option_writes++;
    endfunction

    function bit is_sep(logic [7:0] c);
      case (c)
        8'h2E, 8'h22, 8'h2F, 8'h5B, 8'h5D, fcbp_pkg::CH_COLON, 8'h2B, 8'h3D, 8'h3B,
        8'h2C, fcbp_pkg::CH_TAB, fcbp_pkg::CH_SPACE: return 1'b1;
        default: return (c < 8'd32) || (c >= 8'd128);
      endcase
    endfunction

    function logic [7:0] fold(logic [7:0] c);
      logic [7:0] u;
      u = (c >= fcbp_pkg::CH_LOA && c <= fcbp_pkg::CH_LOZ) ? c - fcbp_pkg::CASE_GAP : c;
      return (c == fcbp_pkg::CH_NUL || is_sep(u)) ? fcbp_pkg::CH_NUL : u;
    endfunction

    function void bump();
      if (count < 8'(fcbp_pkg::COUNT_LIMIT)) count++;
    endfunction

    function void take_name(logic [7:0] g);
      if (g == fcbp_pkg::CH_STAR) begin
        while (name_pos < fcbp_pkg::NAME_LEN) begin
          image[1 + name_pos] = fcbp_pkg::CH_QMARK;
          name_pos++;
        end
        wild = 1'b1;
      end else begin
        image[1 + (name_pos % fcbp_pkg::NAME_LEN)] = g;
        name_pos++;
        if (g == fcbp_pkg::CH_QMARK) wild = 1'b1;
      end
      bump();
      if (name_pos >= fcbp_pkg::NAME_LEN) ph = fcbp_pkg::PH_DOTCHK;
    endfunction

    function void close_parse();
      fcb_word_t w;
      for (int k = 12; k < 16; k++) image[k] = '0;
      for (int k = 0; k < 16; k++) begin
        w.offset = 4'(k);
        w.value  = image[k];
        w.last   = (4'(k) == fcbp_pkg::LAST_OFFSET);
        w.wild   = wild;
        w.count  = count;
        image_bytes_due.push_back(w);
      end
      ph = fcbp_pkg::PH_IDLE;
      parses_closed++;
    endfunction

    function void note_char(logic [7:0] c, logic s);
      logic [7:0] g;
      bit again;
      if (s) begin
        name_pos = 0;
        ext_pos = 0;
        wild = 1'b0;
        count = '0;
        held = '0;
        if (!opts[fcbp_pkg::OPT_KEEP_DRIVE]) image[0] = '0;
        if (!opts[fcbp_pkg::OPT_KEEP_NAME])
          for (int i = 1; i <= fcbp_pkg::NAME_LEN; i++) image[i] = fcbp_pkg::CH_SPACE;
        if (!opts[fcbp_pkg::OPT_KEEP_EXT])
          for (int i = 9; i < 9 + fcbp_pkg::EXT_LEN; i++) image[i] = fcbp_pkg::CH_SPACE;
        ph = opts[fcbp_pkg::OPT_SKIP_SEP] ? fcbp_pkg::PH_SKIPSEP : fcbp_pkg::PH_SKIPWS;
      end
      again = (ph != fcbp_pkg::PH_IDLE);
      while (again) begin
        again = 1'b0;
        case (ph)
          fcbp_pkg::PH_SKIPSEP: begin
            if (c != fcbp_pkg::CH_NUL && is_sep(c) && c != fcbp_pkg::CH_COLON) begin
              bump();
            end else begin
              ph = fcbp_pkg::PH_SKIPWS;
              if (c == fcbp_pkg::CH_COLON) bump();
              else again = 1'b1;
            end
          end
          fcbp_pkg::PH_SKIPWS: begin
            if (c == fcbp_pkg::CH_SPACE || c == fcbp_pkg::CH_TAB) begin
              bump();
            end else if (fold(c) != fcbp_pkg::CH_NUL) begin
              held = c;
              ph = fcbp_pkg::PH_DRVWAIT;
            end else begin
              ph = fcbp_pkg::PH_NAME;
              again = 1'b1;
            end
          end
          fcbp_pkg::PH_DRVWAIT: begin
            g = fold(held);
            if (c == fcbp_pkg::CH_COLON) begin
              image[0] = (g >= fcbp_pkg::CH_UPA && g <= fcbp_pkg::CH_UPZ) ?
                         g - fcbp_pkg::CH_AT : fcbp_pkg::BAD_DRIVE;
              bump();
              bump();
              ph = fcbp_pkg::PH_NAME;
            end else begin
              ph = fcbp_pkg::PH_NAME;
              if (g != fcbp_pkg::CH_NUL) take_name(g);
              again = 1'b1;
            end
          end
          fcbp_pkg::PH_NAME: begin
            g = fold(c);
            if (g == fcbp_pkg::CH_NUL) begin
              ph = fcbp_pkg::PH_DOTCHK;
              again = 1'b1;
            end else begin
              take_name(g);
            end
          end
          fcbp_pkg::PH_DOTCHK: begin
            if (c == fcbp_pkg::CH_DOT) begin
              bump();
              ext_pos = 0;
              ph = fcbp_pkg::PH_EXT;
            end else begin
              close_parse();
            end
          end
          fcbp_pkg::PH_EXT: begin
            g = fold(c);
            if (g == fcbp_pkg::CH_NUL) begin
              close_parse();
            end else begin
              bump();
              if (g == fcbp_pkg::CH_STAR) begin
                while (ext_pos < fcbp_pkg::EXT_LEN) begin
                  image[9 + ext_pos] = fcbp_pkg::CH_QMARK;
                  ext_pos++;
                end
                wild = 1'b1;
                close_parse();
              end else begin
                image[9 + ext_pos] = g;
                ext_pos++;
                if (g == fcbp_pkg::CH_QMARK) wild = 1'b1;
                if (ext_pos >= fcbp_pkg::EXT_LEN) close_parse();
              end
            end
          end
          default: ph = fcbp_pkg::PH_IDLE;
        endcase
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_byte(fcb_word_t got);
      fcb_word_t want;
      bytes_checked++;
      if (image_bytes_due.size() == 0) begin
        report($sformatf("unexpected word, offset %0d byte %h", got.offset, got.value));
        return;
      end
      want = image_bytes_due.pop_front();
      if (got.offset !== want.offset)
        report($sformatf("offset %0d, want %0d", got.offset, want.offset));
      if (got.value !== want.value)
        report($sformatf("byte %h at offset %0d, want %h", got.value, want.offset, want.value));
      if (got.last !== want.last)
        report($sformatf("last %b at offset %0d, want %b", got.last, want.offset, want.last));
      if (got.wild !== want.wild)
        report($sformatf("wildcard %b at offset %0d, want %b", got.wild, want.offset, want.wild));
      if (got.count !== want.count)
        report($sformatf("consumed %0d at offset %0d, want %0d", got.count, want.offset,
                         want.count));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [3:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] ch_i;
  logic       start_req_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [3:0] fcb_offset_o;
  logic [7:0] fcb_byte_o;
  logic       last_o;
  logic       wildcard_res_o;
  logic [7:0] consumed_o;

  fcb_image_tracker tracker;
  int         chars_sent;
  int         steady_in;
  int         idle_cycles;
  logic [3:0] cur_opts;
  logic [7:0] text [$];
  string      sep_chars  = ".\"/[]:+=;,\t ";
  string      letters    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
  string      name_chars = {"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz",
                            "0123456789-_!$#%&'()~@^{}"};

  filename_to_fcb_parser i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ch_i           (ch_i),
    .start_req_i    (start_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fcb_offset_o   (fcb_offset_o),
    .fcb_byte_o     (fcb_byte_o),
    .last_o         (last_o),
    .wildcard_res_o (wildcard_res_o),
    .consumed_o     (consumed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : monitor
    bit moved;
    fcb_word_t got;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        got.offset = fcb_offset_o;
        got.value  = fcb_byte_o;
        got.last   = last_o;
        got.wild   = wildcard_res_o;
        got.count  = consumed_o;
        tracker.check_byte(got);
        moved = 1'b1;
      end
      if (in_valid_i && !in_stall_o) begin
        tracker.note_char(ch_i, start_req_i);
        moved = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        tracker.set_options(cfg_data_i);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(20, 40);
  endfunction

  initial begin
    int quiet;
    int busy;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      quiet = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 6);
      busy = gap_len();
      repeat (quiet) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat (busy) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] name_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return fcbp_pkg::CH_QMARK;
    if (r < 9) return fcbp_pkg::CH_STAR;
    if (r < 13) return 8'($urandom_range(33, 127));
    return pick(name_chars);
  endfunction

  // build one file name: optional separators and blanks, optional drive, name, optional extension, optional end
  function automatic void compose_name();
    int n;
    int r;
    text.delete();
    if (cur_opts[fcbp_pkg::OPT_SKIP_SEP])
      repeat ($urandom_range(0, 3)) text.push_back(pick(sep_chars));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2))
        text.push_back($urandom_range(0, 1) ? fcbp_pkg::CH_SPACE : fcbp_pkg::CH_TAB);
    if ($urandom_range(0, 2) == 0) begin
      text.push_back(($urandom_range(0, 4) == 0) ? pick(name_chars) : pick(letters));
      text.push_back(fcbp_pkg::CH_COLON);
    end
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : $urandom_range(1, 8);
    repeat (n) text.push_back(name_char());
    if ($urandom_range(0, 4) < 3) begin
      text.push_back(fcbp_pkg::CH_DOT);
      repeat ($urandom_range(0, 4)) text.push_back(name_char());
    end
    r = $urandom_range(0, 99);
    if (r < 55) text.push_back(fcbp_pkg::CH_NUL);
    else if (r < 80) text.push_back(pick(sep_chars));
    else if (r < 90) text.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 3)) text.push_back(pick(name_chars));
    if (text.size() == 0) text.push_back(fcbp_pkg::CH_NUL);
  endfunction

  task automatic send_char(logic [7:0] c, logic s);
    int gap;
    if (steady_in > 0) begin
      gap = 0;
      steady_in--;
    end else begin
      gap = gap_len();
      if ($urandom_range(0, 59) == 0) steady_in = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    ch_i <= c;
    start_req_i <= s;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    chars_sent++;
  endtask

  task automatic send_string(string s, bit opening, bit with_nul);
    for (int i = 0; i < s.len(); i++) send_char(s[i], opening && i == 0);
    if (with_nul) send_char(fcbp_pkg::CH_NUL, 1'b0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.image_bytes_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // an empty string always closes a parse, so the block ends idle
  task automatic close_phase();
    send_char(fcbp_pkg::CH_NUL, 1'b1);
    settle();
  endtask

  task automatic write_options(logic [3:0] v);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_opts = v;
  endtask

  initial begin
    int r;
    int cut;
    int mark;
    tracker = new();
    chars_sent = 0;
    steady_in = 0;
    idle_cycles = 0;
    cur_opts = '0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    ch_i = '0;
    start_req_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_options(4'h0);
    send_char("Q", 1'b0);
    send_char(fcbp_pkg::CH_NUL, 1'b1);
    send_string("c:readme.txt", 1'b1, 1'b1);
    send_string("1:x", 1'b1, 1'b1);
    send_string("abcdefghij.k", 1'b1, 1'b1);
    send_string("f*.?x*", 1'b1, 1'b0);
    send_string("ab.cdef", 1'b1, 1'b0);
    send_string("Lo", 1'b1, 1'b0);
    send_char(8'h80, 1'b0);
    send_string("ab", 1'b1, 1'b0);
    send_string("Zz.Q", 1'b1, 1'b1);
    send_string("\t  name?", 1'b1, 1'b1);
    close_phase();

    write_options(4'h1);
    send_string(",;[:  d:x.y", 1'b1, 1'b1);
    send_string("::a", 1'b1, 1'b1);
    close_phase();

    write_options(4'hF);
    send_string("q", 1'b1, 1'b1);
    close_phase();

    write_options(4'hE);
    send_string("*.*", 1'b1, 1'b0);
    send_char(fcbp_pkg::CH_SPACE, 1'b1);
    repeat (SAT_RUN) send_char(fcbp_pkg::CH_SPACE, 1'b0);
    send_string("sat.end", 1'b0, 1'b1);
    close_phase();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_options(4'($urandom_range(0, 15)));
      mark = chars_sent;
      while (chars_sent - mark < PHASE_CHARS) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          repeat ($urandom_range(1, 6))
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        end else begin
          compose_name();
          cut = (r < 25) ? $urandom_range(1, text.size()) : text.size();
          for (int i = 0; i < cut; i++) send_char(text[i], i == 0);
        end
      end
      close_phase();
    end

    $display("Sent %0d characters over %0d option settings; %0d parses closed.",
             chars_sent, tracker.option_writes, tracker.parses_closed);
    $display("Checked %0d image words, %0d mismatches.", tracker.bytes_checked,
             tracker.errors);
    if (tracker.errors == 0 && tracker.image_bytes_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
